// ----- rtl/pes_pkg.sv -----
`timescale 1ns / 1ps
// pes_pkg: shared widths, types and status struct for the polygon edge setup block.
// Used by pes_div and polygon_edge_setup_core; depends on nothing.
package pes_pkg;

    localparam int CoordBits = 12;
    localparam int StepBits  = CoordBits + 1;
    localparam int WideBits  = CoordBits + 2;
    localparam int CntBits   = $clog2(CoordBits);

    typedef logic [CoordBits-1:0] coord_t;
    typedef logic [StepBits-1:0]  step_t;
    typedef logic [WideBits-1:0]  wide_t;
    typedef logic [CntBits-1:0]   cnt_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/pes_div.sv -----
`timescale 1ns / 1ps
// pes_div: bit-serial restoring divider, one quotient bit per cycle.
// Unsigned magnitude divide of two coordinates; uses pes_pkg.
module pes_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pes_pkg::coord_t      dividend,
    input  pes_pkg::coord_t      divisor,
    output pes_pkg::div_status_t status,
    output pes_pkg::coord_t      quotient,
    output pes_pkg::coord_t      remainder
);

    logic                         busy_reg;
    logic                         done_reg;
    pes_pkg::cnt_t                cnt_reg;
    pes_pkg::coord_t              quo_reg;
    pes_pkg::coord_t              rem_reg;
    pes_pkg::coord_t              dvs_reg;
    logic [pes_pkg::CoordBits:0]  shifted;
    logic [pes_pkg::CoordBits:0]  diff;
    logic                         fits;

    assign shifted = {rem_reg, quo_reg[pes_pkg::CoordBits-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= pes_pkg::CntBits'(pes_pkg::CoordBits - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[pes_pkg::CoordBits-2:0], fits};
            rem_reg <= fits ? diff[pes_pkg::CoordBits-1:0] : shifted[pes_pkg::CoordBits-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

// ----- rtl/polygon_edge_setup_core.sv -----
`timescale 1ns / 1ps
// polygon_edge_setup_core: one polygon edge per transfer; orders the vertices and derives
// the scanline range and Bresenham x-stepping terms, plus running y bounds.
// A sloped edge passes through the bit-serial divider before its result is registered; a
// horizontal edge skips the divider. The block takes one edge at a time: the input
// stalls until the result is registered, and longer while a result waits on out_stall.
// Reset (rst_n, async, active low): idle, no result pending, y bounds at 4095 and 0.
module polygon_edge_setup_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pes_pkg::coord_t        prev_x,
    input  pes_pkg::coord_t        prev_y,
    input  pes_pkg::coord_t        cur_x,
    input  pes_pkg::coord_t        cur_y,
    input  logic                   polygon_start,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   edge_valid,
    output pes_pkg::coord_t        top_x,
    output pes_pkg::coord_t        top_line,
    output pes_pkg::coord_t        last_line,
    output pes_pkg::step_t         step_main,
    output pes_pkg::wide_t         step_alt,
    output pes_pkg::wide_t         incr_first,
    output pes_pkg::wide_t         incr_second,
    output pes_pkg::wide_t         error_init,
    output logic                   upward,
    output pes_pkg::coord_t        bound_min,
    output pes_pkg::coord_t        bound_max
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 load;

    logic                 up_in;
    logic                 valid_in;
    logic                 neg_in;
    pes_pkg::coord_t      tx_in;
    pes_pkg::coord_t      ty_in;
    pes_pkg::coord_t      bx_in;
    pes_pkg::coord_t      by_in;
    pes_pkg::coord_t      dy_in;
    pes_pkg::coord_t      dxm_in;
    pes_pkg::coord_t      low_base;
    pes_pkg::coord_t      high_base;

    logic                 valid_reg;
    logic                 up_reg;
    logic                 neg_reg;
    pes_pkg::coord_t      tx_reg;
    pes_pkg::coord_t      ty_reg;
    pes_pkg::coord_t      last_reg;
    pes_pkg::coord_t      dy_reg;
    pes_pkg::coord_t      low_reg;
    pes_pkg::coord_t      high_reg;

    pes_pkg::div_status_t div_st;
    pes_pkg::coord_t      quo;
    pes_pkg::coord_t      rem;
    pes_pkg::wide_t       q_wide;
    pes_pkg::wide_t       q_inc;
    pes_pkg::wide_t       i1;
    pes_pkg::wide_t       i2;

    logic                 out_valid_reg;
    logic                 edge_valid_reg;
    pes_pkg::coord_t      top_x_reg;
    pes_pkg::coord_t      top_line_reg;
    pes_pkg::coord_t      last_line_reg;
    pes_pkg::step_t       step_main_reg;
    pes_pkg::wide_t       step_alt_reg;
    pes_pkg::wide_t       incr_first_reg;
    pes_pkg::wide_t       incr_second_reg;
    pes_pkg::wide_t       error_init_reg;
    logic                 upward_reg;
    pes_pkg::coord_t      bound_min_reg;
    pes_pkg::coord_t      bound_max_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign load     = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // vertex ordering and |dx|
    assign up_in    = (cur_y < prev_y);
    assign valid_in = (cur_y != prev_y);
    assign tx_in    = up_in ? cur_x : prev_x;
    assign ty_in    = up_in ? cur_y : prev_y;
    assign bx_in    = up_in ? prev_x : cur_x;
    assign by_in    = up_in ? prev_y : cur_y;
    assign dy_in    = by_in - ty_in;
    assign neg_in   = (bx_in < tx_in);
    assign dxm_in   = neg_in ? (tx_in - bx_in) : (bx_in - tx_in);

    assign low_base  = polygon_start ? '1 : low_reg;
    assign high_base = polygon_start ? '0 : high_reg;

    pes_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_xfer && valid_in),
        .dividend  (dxm_in),
        .divisor   (dy_in),
        .status    (div_st),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = valid_in ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            low_reg       <= '1;
            high_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_xfer)
            begin
                low_reg  <= (valid_in && (prev_y < low_base)) ? prev_y : low_base;
                high_reg <= (valid_in && (prev_y > high_base)) ? prev_y : high_base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            valid_reg <= valid_in;
            up_reg    <= up_in;
            neg_reg   <= neg_in;
            tx_reg    <= tx_in;
            ty_reg    <= ty_in;
            last_reg  <= by_in - 1'b1;
            dy_reg    <= dy_in;
        end
    end

    // q = |dx| / dy, r = |dx| % dy; incr_first = 2(r - dy), incr_second = 2r
    assign q_wide = pes_pkg::WideBits'(quo);
    assign q_inc  = q_wide + 1'b1;
    assign i1     = (pes_pkg::WideBits'(rem) - pes_pkg::WideBits'(dy_reg)) << 1;
    assign i2     = pes_pkg::WideBits'(rem) << 1;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            edge_valid_reg <= valid_reg;
            bound_min_reg  <= low_reg;
            bound_max_reg  <= high_reg;
            if (valid_reg)
            begin
                top_x_reg       <= tx_reg;
                top_line_reg    <= ty_reg;
                last_line_reg   <= last_reg;
                step_main_reg   <= neg_reg ? pes_pkg::StepBits'(-q_wide)
                                           : pes_pkg::StepBits'(q_wide);
                step_alt_reg    <= neg_reg ? -q_inc : q_inc;
                incr_first_reg  <= i1;
                incr_second_reg <= i2;
                error_init_reg  <= neg_reg ? i1 : i2;
                upward_reg      <= up_reg;
            end
            else
            begin
                top_x_reg       <= '0;
                top_line_reg    <= '0;
                last_line_reg   <= '0;
                step_main_reg   <= '0;
                step_alt_reg    <= '0;
                incr_first_reg  <= '0;
                incr_second_reg <= '0;
                error_init_reg  <= '0;
                upward_reg      <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign edge_valid  = edge_valid_reg;
    assign top_x       = top_x_reg;
    assign top_line    = top_line_reg;
    assign last_line   = last_line_reg;
    assign step_main   = step_main_reg;
    assign step_alt    = step_alt_reg;
    assign incr_first  = incr_first_reg;
    assign incr_second = incr_second_reg;
    assign error_init  = error_init_reg;
    assign upward      = upward_reg;
    assign bound_min   = bound_min_reg;
    assign bound_max   = bound_max_reg;

`ifndef SYNTH
    a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> in_stall)
        else $error("input taken while divider busy");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !edge_valid) |-> (step_main == '0 && error_init == '0 && !upward))
        else $error("horizontal edge result not cleared");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && edge_valid) |-> (bound_min <= bound_max && top_line <= last_line))
        else $error("bounds or scanline range out of order");
`endif

endmodule
